@@ hw/rtl/mono_two_row_pixel_interleaver_unit_assert.svh @@
// Assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef MONO_TWO_ROW_PIXEL_INTERLEAVER_UNIT_ASSERT_SVH
`define MONO_TWO_ROW_PIXEL_INTERLEAVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MTPI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtpi assertion failed");

// Next-cycle implication.
`define MTPI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtpi assertion failed");

`endif

@@ hw/rtl/mtpi_pkg.sv @@
package mtpi_pkg;

	localparam int MAX_ROW_BYTES = 64;
	localparam int COL_W = $clog2(MAX_ROW_BYTES);
	localparam int ROW_BYTES_W = 7;
	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 7'd21;
	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_MAX = ROW_BYTES_W'(MAX_ROW_BYTES);
	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_MIN = 7'd1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] even_byte;
		logic [7:0] odd_byte;
	} pair_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} qstat_t;

	// Bit pairs (even bit k, odd bit k) fill the byte from bit 7 downward.
	function automatic logic [7:0] interleave(input logic [3:0] e, input logic [3:0] o);
		logic [7:0] r;
		r = {e[0], o[0], e[1], o[1], e[2], o[2], e[3], o[3]};
		return r;
	endfunction

endpackage

@@ hw/rtl/mtpi_ifs.sv @@
interface mtpi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       frame_start;

	modport source(output valid, output pixel_byte, output frame_start, input ready);
	modport sink(input valid, input pixel_byte, input frame_start, output ready);
endinterface

interface mtpi_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface

@@ hw/rtl/mtpi_front.sv @@
module mtpi_front import mtpi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ROW_BYTES_W-1:0] cfg_wdata,
	mtpi_in_if.sink                in_ch,
	input  qstat_t                 qstat,
	output logic                   push,
	output pair_t                  push_data
);

	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [COL_W-1:0]       col_q;
	logic                   odd_q;
	logic [7:0]             line_mem [MAX_ROW_BYTES];
	logic [7:0]             even_s1;
	logic [7:0]             odd_s1;
	logic                   valid_s1;

	logic                   accept;
	logic [COL_W-1:0]       col_eff;
	logic                   odd_eff;
	logic [ROW_BYTES_W-1:0] limit;
	logic                   wrap;

	// Leave room in the queue for the word already in flight.
	assign in_ch.ready = ({1'b0, qstat.count} + {{QCNT_W{1'b0}}, valid_s1}) <
		(QCNT_W + 1)'(QDEPTH);
	assign accept = in_ch.valid && in_ch.ready;

	assign col_eff = in_ch.frame_start ? '0 : col_q;
	assign odd_eff = in_ch.frame_start ? 1'b0 : odd_q;

	always_comb begin
		if (row_bytes_q == '0) begin
			limit = ROW_BYTES_MIN;
		end else if (row_bytes_q > ROW_BYTES_MAX) begin
			limit = ROW_BYTES_MAX;
		end else begin
			limit = row_bytes_q;
		end
	end

	assign wrap = ({1'b0, col_eff} + 7'd1) >= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_RST;
			col_q <= '0;
			odd_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				row_bytes_q <= cfg_wdata;
			end
			valid_s1 <= accept && odd_eff;
			if (accept) begin
				if (wrap) begin
					col_q <= '0;
					odd_q <= !odd_eff;
				end else begin
					col_q <= col_eff + COL_W'(1);
					odd_q <= odd_eff;
				end
			end
		end
	end

	// Line store: even rows write, odd rows read the same column.
	always_ff @(posedge clk) begin
		if (accept && !odd_eff) begin
			line_mem[col_eff] <= in_ch.pixel_byte;
		end
		if (accept && odd_eff) begin
			even_s1 <= line_mem[col_eff];
			odd_s1 <= in_ch.pixel_byte;
		end
	end

	assign push = valid_s1;
	assign push_data = '{even_byte: even_s1, odd_byte: odd_s1};

endmodule

@@ hw/rtl/mtpi_queue.sv @@
module mtpi_queue import mtpi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  pair_t  push_data,
	input  logic   pop,
	output pair_t  head,
	output qstat_t qstat
);

	pair_t             slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head = slots_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.full = count_q == QCNT_W'(QDEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/mtpi_back.sv @@
module mtpi_back import mtpi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  pair_t  head,
	input  qstat_t qstat,
	output logic   pop,
	mtpi_out_if.source out_ch
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       phase_q;
	logic       load;

	assign load = (!out_valid_q || out_ch.ready) && !qstat.empty;
	// Drop the pair once its high-nibble word is loaded.
	assign pop = load && phase_q;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q <= !phase_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= phase_q;
			if (phase_q) begin
				out_byte_q <= interleave(head.even_byte[7:4], head.odd_byte[7:4]);
			end else begin
				out_byte_q <= interleave(head.even_byte[3:0], head.odd_byte[3:0]);
			end
		end
	end

endmodule

@@ hw/rtl/mono_two_row_pixel_interleaver_unit.sv @@
// An odd-row byte is paired with its stored even-row byte and queued, then shows
// its low-nibble word and then its high-nibble word; even-row bytes give no word.
// Throughput: one even-row byte per cycle while the queue has room; odd-row bytes
// are limited by the single output register; a 4-entry queue separates intake
// from output. Reset: counters, queue and output valid clear, row_bytes
// returns to 21; the line store keeps its contents and needs no clearing pass.
`include "mono_two_row_pixel_interleaver_unit_assert.svh"

module mono_two_row_pixel_interleaver_unit import mtpi_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ROW_BYTES_W-1:0] cfg_wdata,
	mtpi_in_if.sink                in_ch,
	mtpi_out_if.source             out_ch
);

	qstat_t qstat;
	logic   push;
	pair_t  push_data;
	logic   pop;
	pair_t  head;
	logic   out_take;

	assign out_take = out_ch.valid && out_ch.ready;

	mtpi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	mtpi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	mtpi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	`MTPI_ASSERT_NOW(a_no_push_when_full, push, !qstat.full || pop)
	`MTPI_ASSERT_NOW(a_no_pop_when_empty, pop, !qstat.empty)
	`MTPI_ASSERT_NEXT(a_high_follows_low, out_take && !out_ch.last, out_ch.valid && out_ch.last)
	`MTPI_ASSERT_NOW(a_no_intake_when_full, in_ch.valid && in_ch.ready, !qstat.full)

endmodule

@@ sim/mono_two_row_pixel_interleaver_unit_tb.sv @@
`timescale 1ns / 1ps

module mono_two_row_pixel_interleaver_unit_tb import mtpi_pkg::*;;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_QUOTA = 50;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} woven_word_t;

	// Line store, column and row parity tracked alongside the block.
	class pixel_pair_tracker;
		logic [7:0]  line_store [MAX_ROW_BYTES];
		int unsigned column;
		bit          odd_row;
		int unsigned row_bytes;
		woven_word_t woven_q[$];
		int          mismatches;
		int          words_in;
		int          words_out;

		function new();
			column = 0;
			odd_row = 0;
			row_bytes = ROW_BYTES_RST;
			mismatches = 0;
			words_in = 0;
			words_out = 0;
		endfunction

		function logic [7:0] weave_nibbles(logic [3:0] ev, logic [3:0] od);
			logic [7:0] r;
			for (int k = 0; k < 4; k++) begin
				r[7 - 2 * k] = ev[k];
				r[6 - 2 * k] = od[k];
			end
			return r;
		endfunction

		function void note_word(logic [7:0] pix, logic start);
			int unsigned limit;
			int unsigned col;
			logic [7:0]  ev;
			woven_word_t w;
			words_in++;
			if (start) begin
				column = 0;
				odd_row = 0;
			end
			limit = (row_bytes == 0) ? 1 :
				(row_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_bytes;
			col = (column >= MAX_ROW_BYTES) ? 0 : column;
			if (!odd_row) begin
				line_store[col] = pix;
			end else begin
				ev = line_store[col];
				w.out_byte = weave_nibbles(ev[3:0], pix[3:0]);
				w.last = 1'b0;
				woven_q.push_back(w);
				w.out_byte = weave_nibbles(ev[7:4], pix[7:4]);
				w.last = 1'b1;
				woven_q.push_back(w);
			end
			if (col + 1 >= limit) begin
				column = 0;
				odd_row = !odd_row;
			end else begin
				column = col + 1;
			end
		endfunction

		function void check_word(logic [7:0] out_byte, logic last);
			woven_word_t w;
			words_out++;
			if (woven_q.size() == 0) begin
				$error("unexpected word: out_byte %02h last %0b", out_byte, last);
				mismatches++;
				return;
			end
			w = woven_q.pop_front();
			if (out_byte !== w.out_byte) begin
				$error("out_byte mismatch: expected %02h, actual %02h", w.out_byte, out_byte);
				mismatches++;
			end
			if (last !== w.last) begin
				$error("last mismatch: expected %0b, actual %0b", w.last, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return woven_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [ROW_BYTES_W-1:0] cfg_wdata;

	mtpi_in_if  in_ch();
	mtpi_out_if out_ch();

	mono_two_row_pixel_interleaver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	pixel_pair_tracker tracker;
	int unsigned       cycles;
	bit                gaps_on;
	int                burst_left;
	int                stall_mode;
	int                hold_req;
	int                settings_seen;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel_byte = '0;
		in_ch.frame_start = 1'b0;
		out_ch.ready = 1'b0;
		cycles = 0;
		gaps_on = 1'b1;
		burst_left = 0;
		stall_mode = 0;
		hold_req = 0;
		settings_seen = 1;
		tracker = new();
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles, tracker.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Output side: check accepted words, then pick ready for the next edge.
	initial begin
		int hold_left;
		int tick;
		hold_left = 0;
		tick = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				tracker.check_word(out_ch.out_byte, out_ch.last);
			tick++;
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 9) < 7);
					2: out_ch.ready <= ((tick % 5) != 2) && ((tick % 5) != 3);
					default: out_ch.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic send_word(input logic [7:0] pix, input logic start);
		if (burst_left == 0) begin
			burst_left = gaps_on ? $urandom_range(1, 20) : 1 << 30;
			if (gaps_on)
				repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_byte <= pix;
		in_ch.frame_start <= start;
		do @(posedge clk); while (!in_ch.ready);
		tracker.note_word(pix, start);
		burst_left--;
		if (burst_left == 0)
			in_ch.valid <= 1'b0;
	endtask

	// Drop valid right after the last accepted word of a phase.
	task automatic end_burst();
		if (burst_left != 0) begin
			burst_left = 0;
			in_ch.valid <= 1'b0;
		end
	endtask

	task automatic write_row_bytes(input int unsigned value);
		while (tracker.pending() > 0)
			@(posedge clk);
		// even-row words may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[ROW_BYTES_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.row_bytes = value & ((1 << ROW_BYTES_W) - 1);
		settings_seen++;
	endtask

	task automatic run_phase(input int unsigned value, input int hold);
		int unsigned limit;
		int sent;
		int rows;
		logic start;
		write_row_bytes(value);
		limit = (tracker.row_bytes == 0) ? 1 :
			(tracker.row_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES : tracker.row_bytes;
		hold_req = hold;
		sent = 0;
		while (sent < PHASE_QUOTA) begin
			rows = (limit > 16) ? 2 : 2 * $urandom_range(1, 3);
			// now and then a frame of odd height
			if ($urandom_range(0, 9) == 0)
				rows++;
			for (int r = 0; r < rows; r++) begin
				for (int c = 0; c < limit; c++) begin
					start = (r == 0 && c == 0);
					// occasional restart in the middle of a frame
					if (!start && $urandom_range(0, 149) == 0)
						start = 1'b1;
					send_word(8'($urandom_range(0, 255)), start);
					sent++;
				end
			end
		end
		end_burst();
	endtask

	initial begin
		int unsigned plan [$];
		plan = '{1, 0, 64, 127, 2, 3, 5, 8, 21, 33, 17};
		repeat (3) plan.push_back($urandom_range(1, 64));
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, restarts, odd frame height
		stall_mode = 0;
		gaps_on = 1'b0;
		write_row_bytes(2);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h5A, 1'b0);
		send_word(8'hA5, 1'b0);
		send_word(8'h0F, 1'b0);
		send_word(8'hF0, 1'b0);
		send_word(8'h3C, 1'b1);
		send_word(8'hC3, 1'b0);
		send_word(8'h81, 1'b0);
		send_word(8'h12, 1'b1);
		send_word(8'h34, 1'b0);
		send_word(8'h56, 1'b0);
		send_word(8'h78, 1'b0);
		send_word(8'h9A, 1'b1);
		send_word(8'hBC, 1'b0);
		end_burst();
		// shrink the row while the column sits past the new end
		write_row_bytes(6);
		send_word(8'h11, 1'b1);
		send_word(8'h22, 1'b0);
		send_word(8'h33, 1'b0);
		send_word(8'h44, 1'b0);
		end_burst();
		write_row_bytes(2);
		send_word(8'h55, 1'b0);
		send_word(8'h66, 1'b0);
		send_word(8'h77, 1'b0);
		end_burst();

		foreach (plan[i]) begin
			stall_mode = i % 4;
			gaps_on = (i % 3) != 1;
			run_phase(plan[i], (i == 2 || i == 9) ? 300 : 0);
		end

		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("ran %0d pixel words in, %0d woven words out", tracker.words_in,
			tracker.words_out);
		$display("row lengths exercised: %0d settings incl. 0, 1, 64, 127, with long output hold",
			settings_seen);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ mono_two_row_pixel_interleaver_unit.f @@
+incdir+hw/rtl
hw/rtl/mtpi_pkg.sv
hw/rtl/mtpi_ifs.sv
hw/rtl/mtpi_front.sv
hw/rtl/mtpi_queue.sv
hw/rtl/mtpi_back.sv
hw/rtl/mono_two_row_pixel_interleaver_unit.sv
sim/mono_two_row_pixel_interleaver_unit_tb.sv
